// File: design/okbe_pkg.sv
// Shared types and constants of the ordered key byte encoder.
package okbe_pkg;

   typedef enum logic [1:0] {
      CMD_STR_START = 2'd0,
      CMD_STR_UNIT  = 2'd1,
      CMD_STR_END   = 2'd2,
      CMD_NUMBER    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_STRING_CODE = 2'd0,
      CSR_FLOAT_CODE  = 2'd1,
      CSR_DATE_CODE   = 2'd2,
      CSR_UNUSED      = 2'd3
   } csr_index_type;

   localparam logic [7:0]  STRING_CODE_RST = 8'd48;
   localparam logic [7:0]  FLOAT_CODE_RST  = 8'd16;
   localparam logic [7:0]  DATE_CODE_RST   = 8'd32;

   localparam logic [15:0] ONE_LIMIT  = 16'h007E;
   localparam logic [15:0] TWO_LIMIT  = 16'h3FFF + 16'h007F;
   localparam logic [15:0] TWO_BIAS   = 16'h007F;
   localparam logic [15:0] TWO_MARK   = 16'h8000;
   localparam logic [23:0] THREE_MARK = 24'hC00000;
   localparam int          THREE_SHIFT = 6;

   localparam logic [63:0] SIGN_BIT  = 64'h8000_0000_0000_0000;
   localparam logic [63:0] EXP_MASK  = 64'h7FF0_0000_0000_0000;
   localparam logic [63:0] FRAC_MASK = 64'h000F_FFFF_FFFF_FFFF;

   localparam int JOB_BYTES  = 9;
   localparam int JOB_W      = 8 * JOB_BYTES;
   localparam int JOB_CNT_W  = $clog2(JOB_BYTES + 1);

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      cmd_type     cmd;
      logic [7:0]  type_offset;
      logic        is_date;
      logic [63:0] payload;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_byte;
      logic       bad_value;
   } rsp_type;

   typedef struct packed {
      logic [JOB_W-1:0]     bytes;
      logic [JOB_CNT_W-1:0] count;
      logic                 bad;
   } job_type;

endpackage

// File: design/okbe_front.sv
// Front end: holds the type code registers and turns each command into a byte job.
module okbe_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  okbe_pkg::csr_index_type csr_index,
   input  logic [7:0]            csr_wdata,
   input  okbe_pkg::req_type     req,
   output okbe_pkg::job_type     job
);

   logic [7:0] string_code_ff, float_code_ff, date_code_ff;
   logic [15:0] unit;
   logic [15:0] two_code;
   logic [23:0] three_code;
   logic [63:0] num;
   logic [7:0]  num_code;
   logic        is_nan;

   always_ff @(posedge clock) begin
      if (reset) begin
         string_code_ff <= okbe_pkg::STRING_CODE_RST;
         float_code_ff  <= okbe_pkg::FLOAT_CODE_RST;
         date_code_ff   <= okbe_pkg::DATE_CODE_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            okbe_pkg::CSR_STRING_CODE: string_code_ff <= csr_wdata;
            okbe_pkg::CSR_FLOAT_CODE:  float_code_ff  <= csr_wdata;
            okbe_pkg::CSR_DATE_CODE:   date_code_ff   <= csr_wdata;
            okbe_pkg::CSR_UNUSED:      ;
         endcase
      end
   end

   assign unit       = req.payload[15:0];
   assign two_code   = unit - okbe_pkg::TWO_BIAS + okbe_pkg::TWO_MARK;
   assign three_code = ({8'd0, unit} << okbe_pkg::THREE_SHIFT) | okbe_pkg::THREE_MARK;
   assign is_nan     = ((req.payload & okbe_pkg::EXP_MASK) == okbe_pkg::EXP_MASK) &&
                       ((req.payload & okbe_pkg::FRAC_MASK) != 64'd0);
   assign num        = req.payload[63] ? (64'd0 - req.payload)
                                       : (req.payload | okbe_pkg::SIGN_BIT);
   assign num_code   = (req.is_date ? date_code_ff : float_code_ff) + req.type_offset;

   always_comb begin
      job = '0;
      unique case (req.cmd)
         okbe_pkg::CMD_STR_START: begin
            job.bytes = {string_code_ff + req.type_offset, 64'd0};
            job.count = okbe_pkg::JOB_CNT_W'(1);
         end
         okbe_pkg::CMD_STR_UNIT: begin
            priority if (unit <= okbe_pkg::ONE_LIMIT) begin
               job.bytes = {unit[7:0] + 8'd1, 64'd0};
               job.count = okbe_pkg::JOB_CNT_W'(1);
            end else if (unit <= okbe_pkg::TWO_LIMIT) begin
               job.bytes = {two_code, 56'd0};
               job.count = okbe_pkg::JOB_CNT_W'(2);
            end else begin
               job.bytes = {three_code, 48'd0};
               job.count = okbe_pkg::JOB_CNT_W'(3);
            end
         end
         okbe_pkg::CMD_STR_END: begin
            job.count = okbe_pkg::JOB_CNT_W'(1);
         end
         okbe_pkg::CMD_NUMBER: begin
            if (is_nan) begin
               job.count = okbe_pkg::JOB_CNT_W'(1);
               job.bad   = 1'b1;
            end else begin
               job.bytes = {num_code, num};
               job.count = okbe_pkg::JOB_CNT_W'(okbe_pkg::JOB_BYTES);
            end
         end
      endcase
   end

endmodule

// File: design/okbe_queue.sv
// Job queue between the front end and the byte serializer.
module okbe_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  okbe_pkg::job_type wr_job,
   output logic              full,
   input  logic              rd_en,
   output okbe_pkg::job_type rd_job,
   output logic              empty
);

   okbe_pkg::job_type mem_ff [okbe_pkg::QUEUE_DEPTH];
   logic [okbe_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [okbe_pkg::QUEUE_PTR_W:0]   count_ff, count_in;
   logic do_wr, do_rd;

   assign full  = (count_ff == (okbe_pkg::QUEUE_PTR_W+1)'(okbe_pkg::QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign do_wr = wr_en && !full;
   assign do_rd = rd_en && !empty;
   assign rd_job = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_wr && !do_rd) count_in = count_ff + 1'b1;
      else if (do_rd && !do_wr) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_wr) mem_ff[wr_ptr_ff] <= wr_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_wr) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_rd) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

endmodule

// File: design/okbe_back.sv
// Back end: shifts jobs out one byte per cycle unless stalled, into out_ff.
module okbe_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_avail,
   input  okbe_pkg::job_type job,
   output logic              job_take,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output okbe_pkg::rsp_type rsp_data
);

   logic [okbe_pkg::JOB_W-1:0]     bytes_ff, bytes_in;
   logic [okbe_pkg::JOB_CNT_W-1:0] cnt_ff, cnt_in;
   logic                           bad_ff, bad_in;
   logic                           out_valid_ff, out_valid_in;
   okbe_pkg::rsp_type              out_ff, out_in;
   logic out_free, emit;

   assign out_free = !out_valid_ff || rsp_pop;
   assign emit     = (cnt_ff != '0) && out_free;
   assign job_take = job_avail &&
                     ((cnt_ff == '0) || (emit && cnt_ff == okbe_pkg::JOB_CNT_W'(1)));

   always_comb begin
      bytes_in     = bytes_ff;
      cnt_in       = cnt_ff;
      bad_in       = bad_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (emit) begin
         out_in.out_byte  = bytes_ff[okbe_pkg::JOB_W-1 -: 8];
         out_in.last_byte = (cnt_ff == okbe_pkg::JOB_CNT_W'(1));
         out_in.bad_value = bad_ff;
         out_valid_in     = 1'b1;
         bytes_in         = bytes_ff << 8;
         cnt_in           = cnt_ff - 1'b1;
      end else if (out_free) begin
         out_valid_in = 1'b0;
      end
      if (job_take) begin
         bytes_in = job.bytes;
         cnt_in   = job.count;
         bad_in   = job.bad;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
      bad_ff   <= bad_in;
      out_ff   <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

// File: design/ordered_key_byte_encoder_core.sv
// Top level of the ordered key byte encoder.
//
//   channel   direction   handshake            payload
//   req       in          req_push / req_full  req_data  (okbe_pkg::req_type)
//   rsp       out         rsp_pop / rsp_empty  rsp_data  (okbe_pkg::rsp_type)
//   csr       in          csr_we               csr_index, csr_wdata
//
// A transaction is classified in the cycle it is accepted and waits in a
// four-entry job queue. The serializer sends one byte per cycle unless stalled:
// string units take 1 to 3 bytes, numbers 9 (a rejected NaN 1), other commands
// 1. The result byte is registered. Synchronous reset empties the queue and
// restores the type codes. Full and empty stall each side independently.
module ordered_key_byte_encoder_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  okbe_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output okbe_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [7:0]        csr_wdata
);

   okbe_pkg::job_type front_job, queue_job;
   logic queue_empty, job_take;

   okbe_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (okbe_pkg::csr_index_type'(csr_index)),
      .csr_wdata (csr_wdata),
      .req       (req_data),
      .job       (front_job)
   );

   okbe_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (req_push),
      .wr_job (front_job),
      .full   (req_full),
      .rd_en  (job_take),
      .rd_job (queue_job),
      .empty  (queue_empty)
   );

   okbe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_avail (!queue_empty),
      .job       (queue_job),
      .job_take  (job_take),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// Testbench for the ordered key byte encoder core: directed table, then random key traffic.
module tb;

   localparam int STUCK_LIMIT = 1000;
   localparam int LONG_HOLD   = 150;
   localparam int HOLD_AFTER  = 150;

   typedef struct packed {
      okbe_pkg::req_type req;
      logic              typed;
      logic [7:0]        byte_v;
      logic              bad;
   } row_type;

   logic              clock;
   logic              reset;
   logic              req_push;
   logic              req_full;
   okbe_pkg::req_type req_data;
   logic              rsp_empty;
   logic              rsp_pop;
   okbe_pkg::rsp_type rsp_data;
   logic              csr_we;
   logic [1:0]        csr_index;
   logic [7:0]        csr_wdata;

   logic [7:0]        str_code;
   logic [7:0]        flt_code;
   logic [7:0]        dat_code;
   okbe_pkg::rsp_type pending_bytes[$];
   row_type           stim_rows[$];
   int                mismatches = 0;
   int                bytes_seen = 0;
   int                stuck = 0;
   bit                calm = 0;

   ordered_key_byte_encoder_core uut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_data(req_data),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic void put_byte(input logic [7:0] b, input logic last, input logic bad);
      okbe_pkg::rsp_type r;
      r.out_byte  = b;
      r.last_byte = last;
      r.bad_value = bad;
      pending_bytes.push_back(r);
   endfunction

   function automatic void encode_key(input okbe_pkg::req_type r);
      logic [15:0] unit;
      logic [15:0] two;
      logic [23:0] three;
      logic [63:0] num;
      logic [7:0]  code;
      int          i;
      unit = r.payload[15:0];
      case (r.cmd)
         okbe_pkg::CMD_STR_START: put_byte(str_code + r.type_offset, 1'b1, 1'b0);
         okbe_pkg::CMD_STR_UNIT: begin
            if (unit <= okbe_pkg::ONE_LIMIT) begin
               put_byte(unit[7:0] + 8'd1, 1'b1, 1'b0);
            end else if (unit <= okbe_pkg::TWO_LIMIT) begin
               two = unit - okbe_pkg::TWO_BIAS + okbe_pkg::TWO_MARK;
               put_byte(two[15:8], 1'b0, 1'b0);
               put_byte(two[7:0], 1'b1, 1'b0);
            end else begin
               three = ({8'h00, unit} << okbe_pkg::THREE_SHIFT) | okbe_pkg::THREE_MARK;
               put_byte(three[23:16], 1'b0, 1'b0);
               put_byte(three[15:8], 1'b0, 1'b0);
               put_byte(three[7:0], 1'b1, 1'b0);
            end
         end
         okbe_pkg::CMD_STR_END: put_byte(8'h00, 1'b1, 1'b0);
         default: begin
            if ((r.payload & okbe_pkg::EXP_MASK) == okbe_pkg::EXP_MASK &&
                (r.payload & okbe_pkg::FRAC_MASK) != 64'd0) begin
               put_byte(8'h00, 1'b1, 1'b1);
            end else begin
               num  = r.payload[63] ? (64'd0 - r.payload) : (r.payload | okbe_pkg::SIGN_BIT);
               code = r.is_date ? dat_code : flt_code;
               put_byte(code + r.type_offset, 1'b0, 1'b0);
               for (i = 0; i < 8; i++) put_byte(num[63 - 8 * i -: 8], i == 7, 1'b0);
            end
         end
      endcase
   endfunction

   function automatic void note_failure(input string what, input logic [63:0] want,
                                        input logic [63:0] got);
      if (mismatches < 10) $display("mismatch %0s: expected %0h, got %0h", what, want, got);
      mismatches++;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   function automatic logic [7:0] rand_offset();
      if ($urandom_range(0, 4) == 0) return 8'($urandom_range(0, 255));
      return 8'($urandom_range(0, 160));
   endfunction

   function automatic logic [63:0] rand_unit();
      logic [15:0] u;
      logic [63:0] hi;
      hi = {$urandom(), $urandom()};
      case ($urandom_range(0, 5))
         0: u = 16'($urandom_range(0, 16'h007E));
         1: u = 16'($urandom_range(16'h007F, 16'h407E));
         2: u = 16'($urandom_range(16'h407F, 16'hFFFF));
         3: begin
            case ($urandom_range(0, 5))
               0: u = 16'h0000;
               1: u = okbe_pkg::ONE_LIMIT;
               2: u = okbe_pkg::ONE_LIMIT + 16'd1;
               3: u = okbe_pkg::TWO_LIMIT;
               4: u = okbe_pkg::TWO_LIMIT + 16'd1;
               default: u = 16'hFFFF;
            endcase
         end
         default: u = 16'($urandom());
      endcase
      if ($urandom_range(0, 3) == 0) return {hi[63:16], u};
      return {48'd0, u};
   endfunction

   function automatic logic [63:0] rand_number();
      logic [63:0] bits;
      bits = {$urandom(), $urandom()};
      case ($urandom_range(0, 7))
         0: bits = bits & okbe_pkg::SIGN_BIT;
         1: bits = (bits & okbe_pkg::SIGN_BIT) | okbe_pkg::EXP_MASK;
         2: bits = bits | okbe_pkg::EXP_MASK;
         3: bits[62:52] = 11'($urandom_range(1000, 1050));
         4: bits = bits & (okbe_pkg::SIGN_BIT | okbe_pkg::FRAC_MASK);
         default: ;
      endcase
      return bits;
   endfunction

   function automatic okbe_pkg::req_type noise_req(input okbe_pkg::cmd_type c);
      okbe_pkg::req_type r;
      r.cmd         = c;
      r.type_offset = rand_offset();
      r.is_date     = 1'($urandom());
      r.payload     = {$urandom(), $urandom()};
      return r;
   endfunction

   function automatic void add_row(input okbe_pkg::cmd_type c, input logic [7:0] off,
                                   input logic d, input logic [63:0] p, input logic t,
                                   input logic [7:0] b, input logic bad);
      row_type row;
      row.req.cmd         = c;
      row.req.type_offset = off;
      row.req.is_date     = d;
      row.req.payload     = p;
      row.typed           = t;
      row.byte_v          = b;
      row.bad             = bad;
      stim_rows.push_back(row);
   endfunction

   task automatic send_item(input okbe_pkg::req_type r, input logic typed,
                            input okbe_pkg::rsp_type want);
      int gap;
      gap = calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data <= r;
      req_push <= 1'b1;
      do @(posedge clock); while (req_full);
      if (typed) pending_bytes.push_back(want);
      else encode_key(r);
      @(negedge clock);
   endtask

   task automatic write_code(input okbe_pkg::csr_index_type idx, input logic [7:0] v);
      csr_index <= idx;
      csr_wdata <= v;
      csr_we    <= 1'b1;
      @(negedge clock);
      csr_we    <= 1'b0;
      case (idx)
         okbe_pkg::CSR_STRING_CODE: str_code = v;
         okbe_pkg::CSR_FLOAT_CODE:  flt_code = v;
         okbe_pkg::CSR_DATE_CODE:   dat_code = v;
         default: ;
      endcase
   endtask

   task automatic wait_idle();
      req_push <= 1'b0;
      while (pending_bytes.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic random_keys(input int n);
      int                sent;
      int                k;
      int                j;
      okbe_pkg::req_type r;
      sent = 0;
      while (sent < n) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
               send_item(noise_req(okbe_pkg::CMD_STR_START), 1'b0, '0);
               k = $urandom_range(0, 6);
               for (j = 0; j < k; j++) begin
                  r = noise_req(okbe_pkg::CMD_STR_UNIT);
                  r.payload = rand_unit();
                  send_item(r, 1'b0, '0);
               end
               send_item(noise_req(okbe_pkg::CMD_STR_END), 1'b0, '0);
               sent += k + 2;
            end
            6, 7, 8: begin
               r = noise_req(okbe_pkg::CMD_NUMBER);
               r.payload = rand_number();
               send_item(r, 1'b0, '0);
               sent++;
            end
            default: begin
               r = noise_req(okbe_pkg::cmd_type'($urandom_range(0, 3)));
               send_item(r, 1'b0, '0);
               sent++;
            end
         endcase
      end
   endtask

   // receiver: random stalls, one long hold-off to back up the queue
   initial begin
      int stall;
      bit held;
      held    = 0;
      rsp_pop = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = calm ? 0 : pick_gap();
         if (!held && bytes_seen >= HOLD_AFTER) begin
            stall = LONG_HOLD;
            held  = 1;
         end
         if (stall > 0) begin
            rsp_pop <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_pop <= 1'b1;
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      okbe_pkg::rsp_type want;
      if (!reset) begin
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) stuck = 0;
         else stuck++;
         if (rsp_pop && !rsp_empty) begin
            bytes_seen++;
            if (pending_bytes.size() == 0) begin
               note_failure("unexpected byte", 64'd0, {56'd0, rsp_data.out_byte});
            end else begin
               want = pending_bytes.pop_front();
               if (rsp_data.out_byte !== want.out_byte)
                  note_failure("out_byte", {56'd0, want.out_byte},
                               {56'd0, rsp_data.out_byte});
               if (rsp_data.last_byte !== want.last_byte)
                  note_failure("last_byte", {63'd0, want.last_byte},
                               {63'd0, rsp_data.last_byte});
               if (rsp_data.bad_value !== want.bad_value)
                  note_failure("bad_value", {63'd0, want.bad_value},
                               {63'd0, rsp_data.bad_value});
            end
         end
         if (stuck >= STUCK_LIMIT) begin
            $display("tb: FAIL");
            $finish;
         end
      end
   end

   initial begin
      logic [7:0] c0;
      logic [7:0] c1;
      logic [7:0] c2;
      reset     = 1'b1;
      req_push  = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = okbe_pkg::CSR_STRING_CODE;
      csr_wdata = 8'h00;
      str_code  = okbe_pkg::STRING_CODE_RST;
      flt_code  = okbe_pkg::FLOAT_CODE_RST;
      dat_code  = okbe_pkg::DATE_CODE_RST;

      add_row(okbe_pkg::CMD_STR_START, 8'd0,   1'b0, 64'd0, 1'b1, 8'h30, 1'b0);
      add_row(okbe_pkg::CMD_STR_START, 8'd160, 1'b0, 64'd0, 1'b1, 8'hD0, 1'b0);
      add_row(okbe_pkg::CMD_STR_START, 8'd255, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF,
              1'b1, 8'h2F, 1'b0);
      add_row(okbe_pkg::CMD_STR_UNIT,  8'd0,   1'b0, 64'h0000, 1'b1, 8'h01, 1'b0);
      add_row(okbe_pkg::CMD_STR_UNIT,  8'd0,   1'b0, 64'h007E, 1'b1, 8'h7F, 1'b0);
      add_row(okbe_pkg::CMD_STR_UNIT,  8'd0,   1'b0, 64'h007F, 1'b0, 8'h00, 1'b0);
      add_row(okbe_pkg::CMD_STR_UNIT,  8'd0,   1'b0, 64'h407E, 1'b0, 8'h00, 1'b0);
      add_row(okbe_pkg::CMD_STR_UNIT,  8'd0,   1'b0, 64'h407F, 1'b0, 8'h00, 1'b0);
      add_row(okbe_pkg::CMD_STR_UNIT,  8'd255, 1'b1, 64'hFFFF, 1'b0, 8'h00, 1'b0);
      add_row(okbe_pkg::CMD_STR_UNIT,  8'd255, 1'b1, 64'hFFFF_FFFF_FFFF_0041,
              1'b1, 8'h42, 1'b0);
      add_row(okbe_pkg::CMD_STR_END,   8'd255, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF,
              1'b1, 8'h00, 1'b0);
      add_row(okbe_pkg::CMD_NUMBER, 8'd0,   1'b0, 64'd0, 1'b0, 8'h00, 1'b0);
      add_row(okbe_pkg::CMD_NUMBER, 8'd0,   1'b0, okbe_pkg::SIGN_BIT, 1'b0, 8'h00, 1'b0);
      add_row(okbe_pkg::CMD_NUMBER, 8'd0,   1'b0, 64'h3FF0_0000_0000_0000,
              1'b0, 8'h00, 1'b0);
      add_row(okbe_pkg::CMD_NUMBER, 8'd160, 1'b1, 64'hBFF0_0000_0000_0000,
              1'b0, 8'h00, 1'b0);
      add_row(okbe_pkg::CMD_NUMBER, 8'd0,   1'b0, okbe_pkg::EXP_MASK, 1'b0, 8'h00, 1'b0);
      add_row(okbe_pkg::CMD_NUMBER, 8'd255, 1'b1, 64'hFFF0_0000_0000_0000,
              1'b0, 8'h00, 1'b0);
      add_row(okbe_pkg::CMD_NUMBER, 8'd0,   1'b0, 64'h7FF8_0000_0000_0000,
              1'b1, 8'h00, 1'b1);
      add_row(okbe_pkg::CMD_NUMBER, 8'd7,   1'b1, 64'hFFFF_FFFF_FFFF_FFFF,
              1'b1, 8'h00, 1'b1);
      add_row(okbe_pkg::CMD_NUMBER, 8'd0,   1'b0, 64'h7FF0_0000_0000_0001,
              1'b1, 8'h00, 1'b1);
      add_row(okbe_pkg::CMD_NUMBER, 8'd255, 1'b0, 64'h7FEF_FFFF_FFFF_FFFF,
              1'b0, 8'h00, 1'b0);
      add_row(okbe_pkg::CMD_NUMBER, 8'd1,   1'b1, 64'h0000_0000_0000_0001,
              1'b0, 8'h00, 1'b0);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (stim_rows[i])
         send_item(stim_rows[i].req, stim_rows[i].typed,
                   {stim_rows[i].byte_v, 1'b1, stim_rows[i].bad});

      for (int p = 0; p < 4; p++) begin
         wait_idle();
         case (p)
            0: begin
               c0 = 8'h00;
               c1 = 8'h00;
               c2 = 8'h00;
            end
            1: begin
               c0 = 8'hFF;
               c1 = 8'hFF;
               c2 = 8'hFF;
            end
            default: begin
               c0 = 8'($urandom());
               c1 = 8'($urandom());
               c2 = 8'($urandom());
            end
         endcase
         write_code(okbe_pkg::CSR_STRING_CODE, c0);
         write_code(okbe_pkg::CSR_FLOAT_CODE, c1);
         write_code(okbe_pkg::CSR_DATE_CODE, c2);
         if (p == 2) write_code(okbe_pkg::CSR_UNUSED, 8'($urandom()));
         calm = (p == 1);
         random_keys(48);
      end

      wait_idle();
      repeat (8) @(negedge clock);
      if (mismatches == 0 && pending_bytes.size() == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
